/* rtl/gmn_pkg.sv */
// ----------------------------------------------------------------------------
// gmn_pkg
// shared constants and types for the gradient magnitude normalizer
// ----------------------------------------------------------------------------
package gmn_pkg;

  localparam int GRAD_BITS_DEF = 16;
  localparam int DP_BITS       = 16;   // internal gradient datapath width
  localparam int SQ_BITS       = 32;   // sum of squares and root work width
  localparam int SQRT_CELLS    = 16;
  localparam int NUM_BITS      = 24;   // width of m*255
  localparam int DIV_CELLS     = 8;
  localparam logic [7:0] NORM_FULL = 8'd255;

  localparam logic REQ_MEASURE   = 1'b0;
  localparam logic REQ_NORMALIZE = 1'b1;
  localparam logic MODE_L1       = 1'b0;
  localparam logic MODE_L2       = 1'b1;

  typedef struct packed {
    logic                req;
    logic                fs;
    logic                mode;
    logic                sat;
    logic [DP_BITS-1:0]  l1;
  } gmn_tag_t;

endpackage

/* rtl/gmn_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// gmn_sqrt_cell
// one step of the bitwise integer square root, registered
// ----------------------------------------------------------------------------
module gmn_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_in,
  input  logic [gmn_pkg::SQ_BITS-1:0]  x_in,
  input  logic [gmn_pkg::SQ_BITS-1:0]  res_in,
  input  gmn_pkg::gmn_tag_t            tag_in,
  output logic                         v_out,
  output logic [gmn_pkg::SQ_BITS-1:0]  x_out,
  output logic [gmn_pkg::SQ_BITS-1:0]  res_out,
  output gmn_pkg::gmn_tag_t            tag_out
);
  import gmn_pkg::*;

  localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * STEP);

  logic                v_r;
  logic [SQ_BITS-1:0]  x_r, res_r;
  gmn_tag_t            tag_r;
  logic [SQ_BITS-1:0]  trial;
  logic                ge;

  assign trial = res_in + BIT;
  assign ge    = x_in >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= ge ? (x_in - trial) : x_in;
      res_r <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
      tag_r <= tag_in;
    end
  end

  assign v_out   = v_r;
  assign x_out   = x_r;
  assign res_out = res_r;
  assign tag_out = tag_r;

endmodule

/* rtl/gmn_div_cell.sv */
// ----------------------------------------------------------------------------
// gmn_div_cell
// one restoring division step producing one quotient bit, registered
// ----------------------------------------------------------------------------
module gmn_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  logic [gmn_pkg::NUM_BITS-1:0]  rem_in,
  input  logic [gmn_pkg::DP_BITS-1:0]   d_in,
  input  logic [7:0]                    q_in,
  input  gmn_pkg::gmn_tag_t             tag_in,
  output logic                          v_out,
  output logic [gmn_pkg::NUM_BITS-1:0]  rem_out,
  output logic [gmn_pkg::DP_BITS-1:0]   d_out,
  output logic [7:0]                    q_out,
  output gmn_pkg::gmn_tag_t             tag_out
);
  import gmn_pkg::*;

  logic                 v_r;
  logic [NUM_BITS-1:0]  rem_r;
  logic [DP_BITS-1:0]   d_r;
  logic [7:0]           q_r;
  gmn_tag_t             tag_r;
  logic [NUM_BITS-1:0]  dsh;
  logic                 ge;

  assign dsh = NUM_BITS'(d_in) << SHIFT;
  assign ge  = rem_in >= dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? (rem_in - dsh) : rem_in;
      d_r   <= d_in;
      q_r   <= q_in | (8'(ge) << SHIFT);
      tag_r <= tag_in;
    end
  end

  assign v_out   = v_r;
  assign rem_out = rem_r;
  assign d_out   = d_r;
  assign q_out   = q_r;
  assign tag_out = tag_r;

endmodule

/* rtl/gradient_magnitude_normalize.sv */
// ----------------------------------------------------------------------------
// gradient_magnitude_normalize
// per-pixel L1/L2 gradient magnitude with running-peak byte normalization
// ----------------------------------------------------------------------------
// pipeline: 2 prep stages, the first loaded at the transfer edge, 16 root
//   cells, 1 magnitude stage, 8 divide cells, 1 output register; a stalled
//   result holds the chain and the input
// occupancy: the cell chain holds one item, since a normalizing item needs the
//   peak left by the measuring item before it
// reset: synchronous active-low rst_n clears valids, busy, peak and mode_r
module gradient_magnitude_normalize
  import gmn_pkg::*;
#(
  parameter int GRADIENT_BITS = GRAD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic                      in_frame_start,
  input  logic [GRADIENT_BITS-1:0]  in_gx,
  input  logic [GRADIENT_BITS-1:0]  in_gy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_magnitude
);

  localparam logic [DP_BITS-1:0] LIM = DP_BITS'((1 << (GRADIENT_BITS - 1)) - 1);

  // configuration and control
  logic                mode_r;
  logic                busy_r;
  logic                en;
  logic                in_xfer;
  logic [DP_BITS-1:0]  peak_r;

  // prep stages
  logic                s0_v_r, s1_v_r;
  logic [DP_BITS-1:0]  s0_ax_r, s0_ay_r;
  gmn_tag_t            s0_tag_r, s1_tag_r;
  logic [SQ_BITS-1:0]  s1_sx_r, s1_sy_r;

  // root chain
  logic                sq_v   [0:SQRT_CELLS];
  logic [SQ_BITS-1:0]  sq_x   [0:SQRT_CELLS];
  logic [SQ_BITS-1:0]  sq_res [0:SQRT_CELLS];
  gmn_tag_t            sq_tag [0:SQRT_CELLS];

  // magnitude stage
  logic                mg_v_r;
  logic [NUM_BITS-1:0] mg_num_r;
  gmn_tag_t            mg_tag_r;
  logic [DP_BITS-1:0]  mag;

  // divide chain
  logic                dv_v   [0:DIV_CELLS];
  logic [NUM_BITS-1:0] dv_rem [0:DIV_CELLS];
  logic [DP_BITS-1:0]  dv_d   [0:DIV_CELLS];
  logic [7:0]          dv_q   [0:DIV_CELLS];
  gmn_tag_t            dv_tag [0:DIV_CELLS];
  gmn_tag_t            dv_tag0;

  logic                out_valid_r;
  logic [7:0]          out_mag_r;

  // absolute value, with the most negative code clamped to the limit
  function automatic logic [DP_BITS-1:0] grad_abs(input logic [GRADIENT_BITS-1:0] g);
    logic [DP_BITS-1:0] gs;
    logic [DP_BITS-1:0] a;
    gs = DP_BITS'($signed(g));
    a  = gs[DP_BITS-1] ? (~gs + DP_BITS'(1)) : gs;
    return (a > LIM) ? LIM : a;
  endfunction

  // whole chain moves together; it only holds when the last cell has a
  // normalizing result and the output register is occupied with out_ready low
  assign en       = !(dv_v[DIV_CELLS] && dv_tag[DIV_CELLS].req && out_valid_r && !out_ready);
  assign in_ready = !busy_r;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_L1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
    end else if (dv_v[DIV_CELLS] && en) begin
      busy_r <= 1'b0;
    end
  end

  // stage 0: absolute values and L1 sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_xfer;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax_r      <= grad_abs(in_gx);
      s0_ay_r      <= grad_abs(in_gy);
      s0_tag_r.req  <= in_req_type;
      s0_tag_r.fs   <= in_frame_start;
      s0_tag_r.mode <= mode_r;
      s0_tag_r.sat  <= 1'b0;
      s0_tag_r.l1   <= grad_abs(in_gx) + grad_abs(in_gy);
      // stage 1: squares
      s1_sx_r  <= SQ_BITS'(s0_ax_r) * SQ_BITS'(s0_ax_r);
      s1_sy_r  <= SQ_BITS'(s0_ay_r) * SQ_BITS'(s0_ay_r);
      s1_tag_r <= s0_tag_r;
    end
  end

  // root chain input: sum of squares
  assign sq_v[0]   = s1_v_r;
  assign sq_x[0]   = s1_sx_r + s1_sy_r;
  assign sq_res[0] = '0;
  assign sq_tag[0] = s1_tag_r;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    gmn_sqrt_cell #(.STEP(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (sq_v[k]),
      .x_in    (sq_x[k]),
      .res_in  (sq_res[k]),
      .tag_in  (sq_tag[k]),
      .v_out   (sq_v[k+1]),
      .x_out   (sq_x[k+1]),
      .res_out (sq_res[k+1]),
      .tag_out (sq_tag[k+1])
    );
  end

  // magnitude select and peak tracking
  assign mag = (sq_tag[SQRT_CELLS].mode == MODE_L2) ? sq_res[SQRT_CELLS][DP_BITS-1:0]
                                                    : sq_tag[SQRT_CELLS].l1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      mg_v_r <= 1'b0;
    end else if (en) begin
      mg_v_r <= sq_v[SQRT_CELLS];
      if (sq_v[SQRT_CELLS] && sq_tag[SQRT_CELLS].req == REQ_MEASURE) begin
        if (sq_tag[SQRT_CELLS].fs || mag > peak_r) begin
          peak_r <= mag;
        end
      end
    end
  end

  // m*255 as (m<<8)-m
  always_ff @(posedge clk) begin
    if (en) begin
      mg_num_r <= (NUM_BITS'(mag) << 8) - NUM_BITS'(mag);
      mg_tag_r <= sq_tag[SQRT_CELLS];
    end
  end

  // divisor with zero peak as one; quotient of 256 or more saturates
  always_comb begin
    dv_tag0     = mg_tag_r;
    dv_tag0.sat = mg_num_r >= {(peak_r == '0) ? DP_BITS'(1) : peak_r, 8'd0};
  end

  assign dv_v[0]   = mg_v_r;
  assign dv_rem[0] = mg_num_r;
  assign dv_d[0]   = (peak_r == '0) ? DP_BITS'(1) : peak_r;
  assign dv_q[0]   = '0;
  assign dv_tag[0] = dv_tag0;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    gmn_div_cell #(.SHIFT(DIV_CELLS - 1 - k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (dv_v[k]),
      .rem_in  (dv_rem[k]),
      .d_in    (dv_d[k]),
      .q_in    (dv_q[k]),
      .tag_in  (dv_tag[k]),
      .v_out   (dv_v[k+1]),
      .rem_out (dv_rem[k+1]),
      .d_out   (dv_d[k+1]),
      .q_out   (dv_q[k+1]),
      .tag_out (dv_tag[k+1])
    );
  end

  // output register; only normalizing items produce a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && dv_v[DIV_CELLS] && dv_tag[DIV_CELLS].req == REQ_NORMALIZE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv_v[DIV_CELLS] && dv_tag[DIV_CELLS].req == REQ_NORMALIZE) begin
      out_mag_r <= dv_tag[DIV_CELLS].sat ? NORM_FULL : dv_q[DIV_CELLS];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;

endmodule

/* rtl/gmn_checker.sv */
// ----------------------------------------------------------------------------
// gmn_assert
// port-level checks for the gradient magnitude normalizer
// ----------------------------------------------------------------------------
module gmn_assert (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_magnitude
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude))
    else $error("result changed while stalled");

  // one item at a time: no new transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind gradient_magnitude_normalize gmn_assert u_gmn_assert (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_magnitude (out_magnitude)
);
